// ----- rtl/m4vt_pkg.sv -----
package m4vt_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = $clog2(NumRegs);
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned QW       = 32;
  localparam int unsigned ProdW    = 2 * QW;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumLanes = 4;

  localparam logic [QW-1:0] OneQ16 = 32'h0001_0000;
  localparam logic [QW-1:0] QMax   = 32'h7fff_ffff;
  localparam logic [QW-1:0] QMin   = 32'h8000_0000;

  localparam logic [CfgIdxW-1:0] RegR0C01 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegR0C23 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegR1C01 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegR1C23 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegR2C01 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegR2C23 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegR3C01 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegR3C23 = 3'd7;

  localparam logic [CfgDataW-1:0] DiagLow  = {32'h0, OneQ16};
  localparam logic [CfgDataW-1:0] DiagHigh = {OneQ16, 32'h0};

  typedef logic [QW-1:0] q16_t;
  typedef q16_t [NumLanes-1:0] vec4_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    q16_t value;
    logic ovf;
  } lane_res_t;

endpackage

// ----- rtl/matrix4_vector_transform.sv -----
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// item in  | start & !busy          | item_i (mode, in_x, in_y, in_z, in_w)
// result   | res_valid_o, 1 cycle   | res_o (out_x..out_w, overflow)
// config   | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// one item per cycle; each result passes the multiply, pair add and
// final add and saturate registers in each row lane, then the merge register
// busy is always low: the four row lanes are fully pipelined
// reset loads the identity matrix and empties the pipeline
// the receiver cannot stall; every result is shown for exactly one cycle
module matrix4_vector_transform
  import m4vt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  in_item_t            item_i,
  output logic                res_valid_o,
  output out_item_t           res_o
);

  localparam int unsigned LaneDepth = 3;

  logic [CfgDataW-1:0] mat_q [NumRegs];
  logic [LaneDepth-1:0] valid_q, mode_q;
  logic                 accept;
  vec4_t                vec;
  vec4_t                coef [NumLanes];
  lane_res_t            lane_res [NumLanes];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        mat_q[i] <= '0;
      end
      mat_q[RegR0C01] <= DiagLow;
      mat_q[RegR1C01] <= DiagHigh;
      mat_q[RegR2C23] <= DiagLow;
      mat_q[RegR3C23] <= DiagHigh;
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[LaneDepth-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= {mode_q[LaneDepth-2:0], item_i.mode};
  end

  always_comb begin
    vec[0] = item_i.in_x;
    vec[1] = item_i.in_y;
    vec[2] = item_i.in_z;
    vec[3] = item_i.mode ? OneQ16 : item_i.in_w;
  end

  for (genvar r = 0; r < NumLanes; r++) begin : g_lane
    for (genvar c = 0; c < NumLanes; c++) begin : g_coef
      assign coef[r][c] = mat_q[r * 2 + c / 2][(c % 2) * QW +: QW];
    end

    m4vt_lane u_lane (
      .clk_i  (clk_i),
      .coef_i (coef[r]),
      .vec_i  (vec),
      .res_o  (lane_res[r])
    );
  end

  m4vt_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_q[LaneDepth-1]),
    .mode_i  (mode_q[LaneDepth-1]),
    .lane_i  (lane_res),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

endmodule

// ----- rtl/m4vt_lane.sv -----
module m4vt_lane
  import m4vt_pkg::*;
(
  input  logic      clk_i,
  input  vec4_t     coef_i,
  input  vec4_t     vec_i,
  output lane_res_t res_o
);

  localparam int unsigned SumW = ProdW + 2;
  localparam int unsigned ShW  = SumW - FracW;

  logic signed [ProdW-1:0] prod_q [NumLanes];
  logic signed [ProdW:0]   sum01_q, sum23_q;
  logic signed [SumW-1:0]  total;
  logic [ShW-1:0]          shifted;
  logic                    in_range;
  lane_res_t               res_d, res_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NumLanes; c++) begin
      prod_q[c] <= ProdW'($signed(coef_i[c])) * ProdW'($signed(vec_i[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    sum01_q <= {prod_q[0][ProdW-1], prod_q[0]} + {prod_q[1][ProdW-1], prod_q[1]};
    sum23_q <= {prod_q[2][ProdW-1], prod_q[2]} + {prod_q[3][ProdW-1], prod_q[3]};
  end

  // floor shift by the fraction width is the upper part of the exact sum
  always_comb begin
    total    = {sum01_q[ProdW], sum01_q} + {sum23_q[ProdW], sum23_q};
    shifted  = total[SumW-1:FracW];
    in_range = (&shifted[ShW-1:QW-1]) || !(|shifted[ShW-1:QW-1]);
    if (in_range) begin
      res_d.value = shifted[QW-1:0];
      res_d.ovf   = 1'b0;
    end else begin
      res_d.value = shifted[ShW-1] ? QMin : QMax;
      res_d.ovf   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

// ----- rtl/m4vt_merge.sv -----
module m4vt_merge
  import m4vt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  logic      mode_i,
  input  lane_res_t lane_i [NumLanes],
  output logic      valid_o,
  output out_item_t res_o
);

  logic      valid_q;
  out_item_t res_d, res_q;

  // point mode drops the w row entirely
  always_comb begin
    res_d.out_x    = lane_i[0].value;
    res_d.out_y    = lane_i[1].value;
    res_d.out_z    = lane_i[2].value;
    res_d.out_w    = mode_i ? '0 : lane_i[3].value;
    res_d.overflow = lane_i[0].ovf | lane_i[1].ovf | lane_i[2].ovf
                   | (lane_i[3].ovf & ~mode_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- rtl/m4vt_checker.sv -----
module m4vt_checker
  import m4vt_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  item_i,
  input logic      res_valid_o,
  input out_item_t res_o
);

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("block signaled busy");

  a_item_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##4 res_valid_o)
    else $error("accepted item produced no result");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start, 4) && !$past(busy, 4) && $past(rst_ni, 4))
    else $error("result without an accepted item");

  a_point_w_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.mode |-> ##4 (res_o.out_w == '0))
    else $error("point item gave nonzero w");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
